// File: rtl/svbt_pkg.sv
// Shared types, codes and defaults for the sparse voxel boundary table.
package svbt_pkg;

    localparam int TableEntriesDef = 256;
    localparam int CoordBitsDef    = 16;

    // operation codes
    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IDLE   = 2'd3
    } op_e;

    // boundary kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_FREE     = 2'd1;
    localparam logic [1:0] KIND_FRONTIER = 2'd2;
    localparam logic [1:0] KIND_OCCUPIED = 2'd3;

    // grid states
    localparam logic [1:0] GRID_UNKNOWN  = 2'd0;
    localparam logic [1:0] GRID_FREE     = 2'd1;
    localparam logic [1:0] GRID_OCCUPIED = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_FINISH = 2'd3
    } state_e;

    typedef struct packed {
        logic [1:0]        operation;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic [1:0]        boundary_kind;
    } item_t;

    typedef struct packed {
        logic [1:0]  grid_state;
        logic [1:0]  found_kind;
        logic        changed;
        logic        table_full;
        logic [31:0] change_count;
    } result_t;

    // classified job control travelling from front to back
    typedef struct packed {
        op_e        op;
        logic [1:0] kind;
    } job_ctl_t;

    function automatic logic [1:0] state_of(input logic [1:0] kind);
        logic [1:0] g;
        g = GRID_UNKNOWN;
        if (kind == KIND_FREE)
            g = GRID_FREE;
        else if (kind == KIND_OCCUPIED)
            g = GRID_OCCUPIED;
        return g;
    endfunction

endpackage

// File: rtl/sparse_voxel_boundary_table_core.sv
// Top level of the sparse voxel boundary table.
// The table keeps up to TABLE_ENTRIES voxels in one single-port entry memory
// that is read one entry per cycle. An update or lookup word walks the whole
// memory in the scan state, then the finish state registers its result word;
// a clear word or an unused operation code has its result word registered
// straight from the idle state. A clear, and reset, start a clearing pass over
// all TABLE_ENTRIES entries during which no further word is started. A two-deep
// input queue keeps taking words while the back end works or a result word is stalled.
module sparse_voxel_boundary_table_core #(
    parameter int TABLE_ENTRIES = svbt_pkg::TableEntriesDef,
    parameter int COORD_BITS    = svbt_pkg::CoordBitsDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  svbt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output svbt_pkg::result_t result
);

    logic                  job_valid;
    logic                  pop;
    svbt_pkg::job_ctl_t    job_ctl;
    logic [COORD_BITS-1:0] job_x, job_y, job_z;

    svbt_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (pop),
        .job_valid  (job_valid),
        .job_ctl    (job_ctl),
        .job_x      (job_x),
        .job_y      (job_y),
        .job_z      (job_z)
    );

    svbt_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COORD_BITS   (COORD_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .pop          (pop),
        .job_ctl      (job_ctl),
        .job_x        (job_x),
        .job_y        (job_y),
        .job_z        (job_z),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // a dropped insert never counts as a change
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.changed && result.table_full))
        else $error("changed and table_full both set");

    // lookup fields stay zero on an update that changed the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.changed) |->
            (result.grid_state == svbt_pkg::GRID_UNKNOWN &&
             result.found_kind == svbt_pkg::KIND_NONE))
        else $error("lookup fields set on a changing update");

    // a popped job is never taken while a result is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (job_valid && !result_valid))
        else $error("job started while result pending");

endmodule

// File: rtl/svbt_front.sv
// Front end: accepts words, forms biased coordinate keys, two-deep job queue.
module svbt_front #(
    parameter int COORD_BITS = svbt_pkg::CoordBitsDef
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  svbt_pkg::item_t        item,
    input  logic                   pop,
    output logic                   job_valid,
    output svbt_pkg::job_ctl_t     job_ctl,
    output logic [COORD_BITS-1:0]  job_x,
    output logic [COORD_BITS-1:0]  job_y,
    output logic [COORD_BITS-1:0]  job_z
);

    localparam int KW = COORD_BITS;

    // wrap to KW bits two's complement, flip sign so unsigned compare orders
    function automatic logic [KW-1:0] key_of(input logic signed [15:0] c);
        logic signed [31:0] s;
        logic [KW-1:0]      k;
        s = 32'(c);
        k = s[KW-1:0];
        k[KW-1] = ~k[KW-1];
        return k;
    endfunction

    svbt_pkg::job_ctl_t q_ctl_reg [2];
    logic [KW-1:0]      q_x_reg [2];
    logic [KW-1:0]      q_y_reg [2];
    logic [KW-1:0]      q_z_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push;

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign job_valid  = (count_reg != 2'd0);
    assign job_ctl    = q_ctl_reg[rd_ptr_reg];
    assign job_x      = q_x_reg[rd_ptr_reg];
    assign job_y      = q_y_reg[rd_ptr_reg];
    assign job_z      = q_z_reg[rd_ptr_reg];

    // queue pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && job_valid);
        count_next  = count_reg + 2'(push) - 2'(pop && job_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_ctl_reg[wr_ptr_reg] <= '{op: svbt_pkg::op_e'(item.operation),
                                       kind: item.boundary_kind};
            q_x_reg[wr_ptr_reg]   <= key_of(item.cell_x);
            q_y_reg[wr_ptr_reg]   <= key_of(item.cell_y);
            q_z_reg[wr_ptr_reg]   <= key_of(item.cell_z);
        end
    end

endmodule

// File: rtl/svbt_engine.sv
// Back end: entry memory, scan sequencer, write-back and result register.
module svbt_engine #(
    parameter int TABLE_ENTRIES = svbt_pkg::TableEntriesDef,
    parameter int COORD_BITS    = svbt_pkg::CoordBitsDef
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   pop,
    input  svbt_pkg::job_ctl_t     job_ctl,
    input  logic [COORD_BITS-1:0]  job_x,
    input  logic [COORD_BITS-1:0]  job_y,
    input  logic [COORD_BITS-1:0]  job_z,
    output logic                   result_valid,
    input  logic                   result_stall,
    output svbt_pkg::result_t      result
);

    localparam int KW = COORD_BITS;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int EW = 1 + 3 * KW + 2;
    localparam logic [CW-1:0] LastIdx = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] EndIdx  = CW'(TABLE_ENTRIES);

    // entry: {valid, x, y, z, kind}
    logic [EW-1:0] mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;

    svbt_pkg::state_e   state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IW-1:0]      proc_idx_reg, proc_idx_next;
    svbt_pkg::job_ctl_t ctl_reg, ctl_next;
    logic [KW-1:0]      kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic               hit_found_reg, hit_found_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    logic [1:0]         hit_kind_reg, hit_kind_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               best_found_reg, best_found_next;
    logic [KW-1:0]      best_z_reg, best_z_next;
    logic [1:0]         best_kind_reg, best_kind_next;
    logic [31:0]        changes_reg, changes_next;
    logic               res_vld_reg, res_vld_next;
    svbt_pkg::result_t  res_reg, res_next;

    logic               e_valid, col, fin_changed, fin_full;
    logic [KW-1:0]      e_x, e_y, e_z;
    logic [1:0]         e_kind;

    assign {e_valid, e_x, e_y, e_z, e_kind} = rd_data_reg;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        proc_idx_next   = proc_idx_reg;
        ctl_next        = ctl_reg;
        kx_next         = kx_reg;
        ky_next         = ky_reg;
        kz_next         = kz_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_kind_next   = hit_kind_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_z_next     = best_z_reg;
        best_kind_next  = best_kind_reg;
        changes_next    = changes_reg;
        res_vld_next    = res_vld_reg && result_stall;
        res_next        = res_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[IW-1:0];
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IW-1:0];
        wr_data         = {1'b0, kx_reg, ky_reg, kz_reg, ctl_reg.kind};
        col             = e_valid && (e_x == kx_reg) && (e_y == ky_reg);
        fin_changed     = 1'b0;
        fin_full        = 1'b0;

        unique case (state_reg)
            // clearing pass: one entry per cycle
            svbt_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_data  = '0;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LastIdx)
                    state_next = svbt_pkg::ST_IDLE;
            end

            svbt_pkg::ST_IDLE:
            begin
                if (job_valid && !res_vld_reg)
                begin
                    pop             = 1'b1;
                    ctl_next        = job_ctl;
                    kx_next         = job_x;
                    ky_next         = job_y;
                    kz_next         = job_z;
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    res_next        = '0;
                    priority case (job_ctl.op)
                        svbt_pkg::OP_UPDATE, svbt_pkg::OP_LOOKUP:
                            state_next = svbt_pkg::ST_SCAN;
                        svbt_pkg::OP_CLEAR:
                        begin
                            changes_next = '0;
                            res_vld_next = 1'b1;
                            state_next   = svbt_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            res_next.change_count = changes_reg;
                            res_vld_next          = 1'b1;
                        end
                    endcase
                end
            end

            // stream every entry past the compare logic
            svbt_pkg::ST_SCAN:
            begin
                if (cnt_reg != EndIdx)
                begin
                    rd_en         = 1'b1;
                    rd_pend_next  = 1'b1;
                    proc_idx_next = cnt_reg[IW-1:0];
                    cnt_next      = cnt_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = svbt_pkg::ST_FINISH;
                end
                if (rd_pend_reg)
                begin
                    if (col && (e_z == kz_reg))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = proc_idx_reg;
                        hit_kind_next  = e_kind;
                    end
                    if (!e_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx_reg;
                    end
                    if (col && (e_z >= kz_reg) && (!best_found_reg || e_z < best_z_reg))
                    begin
                        best_found_next = 1'b1;
                        best_z_next     = e_z;
                        best_kind_next  = e_kind;
                    end
                end
            end

            // write back and form the result
            svbt_pkg::ST_FINISH:
            begin
                state_next = svbt_pkg::ST_IDLE;
                if (ctl_reg.op == svbt_pkg::OP_UPDATE)
                begin
                    if (ctl_reg.kind == svbt_pkg::KIND_NONE)
                    begin
                        if (hit_found_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = hit_idx_reg;
                            fin_changed = 1'b1;
                        end
                    end
                    else if (hit_found_reg)
                    begin
                        if (hit_kind_reg != ctl_reg.kind)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = hit_idx_reg;
                            wr_data[EW-1] = 1'b1;
                            fin_changed = 1'b1;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = free_idx_reg;
                        wr_data[EW-1] = 1'b1;
                        fin_changed = 1'b1;
                    end
                    else
                    begin
                        fin_full = 1'b1;
                    end
                end
                else if (best_found_reg)
                begin
                    if (best_z_reg == kz_reg)
                    begin
                        res_next.found_kind = best_kind_reg;
                        res_next.grid_state = svbt_pkg::state_of(best_kind_reg);
                    end
                    else if (best_kind_reg == svbt_pkg::KIND_FREE)
                    begin
                        res_next.grid_state = svbt_pkg::GRID_FREE;
                    end
                end
                changes_next          = changes_reg + 32'(fin_changed);
                res_next.changed      = fin_changed;
                res_next.table_full   = fin_full;
                res_next.change_count = changes_next;
                res_vld_next          = 1'b1;
            end

            default:
                state_next = svbt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= svbt_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            changes_reg <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            changes_reg <= changes_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // job payload and search trackers
    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        ctl_reg        <= ctl_next;
        kx_reg         <= kx_next;
        ky_reg         <= ky_next;
        kz_reg         <= kz_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_kind_reg   <= hit_kind_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_z_reg     <= best_z_next;
        best_kind_reg  <= best_kind_next;
        res_reg        <= res_next;
    end

endmodule

// File: tb/sv/tb.sv
// Testbench for the sparse voxel boundary table core.
`timescale 1ns / 100ps

module tb;

    localparam int ENTRIES   = svbt_pkg::TableEntriesDef;
    localparam int MAX_CYCLE = 4000000;
    localparam int LONG_HOLD = 3 * ENTRIES + 200;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    svbt_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall = 1'b0;
    svbt_pkg::result_t result;

    sparse_voxel_boundary_table_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predicted table contents
    logic              vox_used [ENTRIES];
    logic signed [15:0] vox_x   [ENTRIES];
    logic signed [15:0] vox_y   [ENTRIES];
    logic signed [15:0] vox_z   [ENTRIES];
    logic [1:0]        vox_kind [ENTRIES];
    logic [31:0]       change_total;

    svbt_pkg::result_t pending_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    logic    send_gaps;
    logic    recv_gaps;
    int      hold_cycles = 0;
    int      hold_req = 0;
    int      hold_ack = 0;

    // coordinates drawn from a small pool so columns collide often
    logic signed [15:0] pool_xy [4] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};

    // apply one word to the predicted table, return the expected result
    function automatic svbt_pkg::result_t table_apply(input svbt_pkg::item_t w);
        svbt_pkg::result_t r;
        int hit;
        int slot;
        int best;
        r    = '0;
        hit  = -1;
        slot = -1;
        best = -1;
        unique case (svbt_pkg::op_e'(w.operation))
            svbt_pkg::OP_UPDATE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (vox_used[i])
                    begin
                        if (vox_x[i] == w.cell_x && vox_y[i] == w.cell_y
                            && vox_z[i] == w.cell_z)
                            hit = i;
                    end
                    else if (slot < 0)
                        slot = i;
                end
                if (w.boundary_kind == svbt_pkg::KIND_NONE)
                begin
                    if (hit >= 0)
                    begin
                        vox_used[hit] = 1'b0;
                        r.changed = 1'b1;
                    end
                end
                else if (hit >= 0)
                begin
                    if (vox_kind[hit] != w.boundary_kind)
                    begin
                        vox_kind[hit] = w.boundary_kind;
                        r.changed = 1'b1;
                    end
                end
                else if (slot >= 0)
                begin
                    vox_used[slot] = 1'b1;
                    vox_x[slot]    = w.cell_x;
                    vox_y[slot]    = w.cell_y;
                    vox_z[slot]    = w.cell_z;
                    vox_kind[slot] = w.boundary_kind;
                    r.changed = 1'b1;
                end
                else
                    r.table_full = 1'b1;
                if (r.changed)
                    change_total++;
            end
            svbt_pkg::OP_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (vox_used[i] && vox_x[i] == w.cell_x && vox_y[i] == w.cell_y
                        && vox_z[i] >= w.cell_z && (best < 0 || vox_z[i] < vox_z[best]))
                        best = i;
                if (best >= 0)
                begin
                    if (vox_z[best] == w.cell_z)
                    begin
                        r.found_kind = vox_kind[best];
                        if (vox_kind[best] == svbt_pkg::KIND_FREE)
                            r.grid_state = svbt_pkg::GRID_FREE;
                        else if (vox_kind[best] == svbt_pkg::KIND_OCCUPIED)
                            r.grid_state = svbt_pkg::GRID_OCCUPIED;
                    end
                    else if (vox_kind[best] == svbt_pkg::KIND_FREE)
                        r.grid_state = svbt_pkg::GRID_FREE;
                end
            end
            svbt_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    vox_used[i] = 1'b0;
                change_total = '0;
            end
            default: ;
        endcase
        r.change_count = change_total;
        return r;
    endfunction

    // append one expected result word
    task automatic queue_expected(input svbt_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // send one word, predict at acceptance; valid stays up between words except in random send gaps
    task automatic send_word(input svbt_pkg::op_e op, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z,
                             input logic [1:0] kind);
        svbt_pkg::item_t w;
        w.operation     = op;
        w.cell_x        = x;
        w.cell_y        = y;
        w.cell_z        = z;
        w.boundary_kind = kind;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        queue_expected(table_apply(w));
    endtask

    task automatic send_random_coord(input svbt_pkg::op_e op, input logic [1:0] kind);
        send_word(op, pool_xy[$urandom_range(0, 3)], pool_xy[$urandom_range(0, 3)],
                  16'($urandom_range(0, 11)) - 16'sd6, kind);
    endtask

    // wait until every result has come back
    task automatic drain;
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 10) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        svbt_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.grid_state != want.grid_state)
                    report_mismatch("grid_state", 32'(result.grid_state),
                                    32'(want.grid_state));
                if (result.found_kind != want.found_kind)
                    report_mismatch("found_kind", 32'(result.found_kind),
                                    32'(want.found_kind));
                if (result.changed != want.changed)
                    report_mismatch("changed", 32'(result.changed), 32'(want.changed));
                if (result.table_full != want.table_full)
                    report_mismatch("table_full", 32'(result.table_full),
                                    32'(want.table_full));
                if (result.change_count != want.change_count)
                    report_mismatch("change_count", result.change_count, want.change_count);
            end
        end
    end

    // receiver stall: long hold-off on request, else random bursts
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_cycles  <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (recv_gaps && $urandom_range(0, 5) == 0)
        begin
            hold_cycles  <= $urandom_range(1, 17);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("sparse_voxel_boundary_table_core verification failed");
            $finish;
        end
    end

    task automatic test_directed;
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh8000, 16'sh8000, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, 16'sh7fff, svbt_pkg::KIND_FREE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, 16'sh7fff, svbt_pkg::KIND_FREE);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, 16'sh8000, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, 16'sh7fff, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  svbt_pkg::KIND_OCCUPIED);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, 16'sh7fff, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, -16'sd1,
                  svbt_pkg::KIND_FRONTIER);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, -16'sd2, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, -16'sd1, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh7fff, 16'sh8000, -16'sd5, svbt_pkg::KIND_FREE);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh7fff, 16'sh8000, 16'sh8000, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, 16'sd3, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_UPDATE, 16'sh8000, 16'sh7fff, -16'sd1, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_IDLE, -16'sd1, -16'sd1, -16'sd1, svbt_pkg::KIND_OCCUPIED);
        send_word(svbt_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, svbt_pkg::KIND_NONE);
        send_word(svbt_pkg::OP_LOOKUP, 16'sh8000, 16'sh7fff, 16'sh7fff, svbt_pkg::KIND_NONE);
        drain();
    endtask

    // fill the table past capacity while the receiver holds off
    task automatic test_full_table;
        hold_req = hold_req + 1;
        for (int i = 0; i < ENTRIES + 3; i++)
            send_word(svbt_pkg::OP_UPDATE, 16'(i), 16'($urandom), 16'($urandom),
                      2'($urandom_range(1, 3)));
        send_word(svbt_pkg::OP_UPDATE, 16'sd4, 16'sd0, 16'sd0, svbt_pkg::KIND_FREE);
        send_word(svbt_pkg::OP_UPDATE, 16'sd7, 16'sd0, 16'sd0, svbt_pkg::KIND_NONE);
        for (int i = 0; i < 4; i++)
            send_random_coord(svbt_pkg::OP_UPDATE, 2'($urandom_range(1, 3)));
        send_word(svbt_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, svbt_pkg::KIND_NONE);
        drain();
    endtask

    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_random_coord(svbt_pkg::OP_UPDATE, 2'($urandom));
            else if (pick < 93)
                send_random_coord(svbt_pkg::OP_LOOKUP, 2'($urandom));
            else if (pick < 96)
                send_word(svbt_pkg::OP_UPDATE, 16'($urandom), 16'($urandom),
                          16'($urandom), 2'($urandom));
            else if (pick < 98)
                send_word(svbt_pkg::OP_IDLE, 16'($urandom), 16'($urandom),
                          16'($urandom), 2'($urandom));
            else
                send_word(svbt_pkg::OP_CLEAR, 16'($urandom), 16'($urandom),
                          16'($urandom), 2'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        change_total = '0;
        for (int i = 0; i < ENTRIES; i++)
            vox_used[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random(520);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random(150);
        if (error_count == 0)
            $display("sparse_voxel_boundary_table_core verification clean");
        else
            $display("sparse_voxel_boundary_table_core verification failed");
        $finish;
    end

endmodule
